// File: hw/rtl/kmer_count_histogram_defines.svh
// Assertion macros used by the k-mer counter checker
`ifndef KMER_COUNT_HISTOGRAM_DEFINES_SVH
`define KMER_COUNT_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define KCH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define KCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/kch_pkg.sv
// Shared types and constants of the k-mer counter
package kch_pkg;

  // op field codes
  localparam logic [1:0] OP_SHIFT = 2'd0;
  localparam logic [1:0] OP_RAW   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // k-mer length after reset
  localparam logic [3:0] KSIZE_RESET = 4'd8;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DEC,
    S_INC,
    S_DONE
  } kch_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic look;
    logic dec;
    logic inc;
    logic emit;
  } kch_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic will_count;
  } kch_sts_t;

endpackage

// File: hw/rtl/kch_ifs.sv
// Valid/ready channel interfaces for input words and result words

interface kch_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [1:0]  symbol;
  logic [15:0] raw_key;
  logic [9:0]  count_index;

  modport source (output valid, op, symbol, raw_key, count_index, input ready);
  modport sink   (input valid, op, symbol, raw_key, count_index, output ready);
endinterface

interface kch_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] kmer_code;
  logic        was_counted;
  logic [16:0] hist_entry;
  logic [9:0]  largest_count;
  logic        count_saturated;

  modport source (output valid, kmer_code, was_counted, hist_entry, largest_count,
                  count_saturated, input ready);
  modport sink   (input valid, kmer_code, was_counted, hist_entry, largest_count,
                  count_saturated, output ready);
endinterface

// File: hw/rtl/kch_ram.sv
// Generic single-write, single-read RAM with registered read data
module kch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/kch_ctrl.sv
// Sequencer: clearing pass, item steps and output word handshake
module kch_ctrl import kch_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  kch_sts_t sts,
  output kch_cmd_t cmd
);

  kch_state_t state;
  kch_state_t state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_LOOK;
      S_LOOK:  state_next = sts.will_count ? S_DEC : S_DONE;
      S_DEC:   state_next = S_INC;
      S_INC:   state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_LOOK:  cmd.look = 1'b1;
      S_DEC:   cmd.dec  = 1'b1;
      S_INC:   cmd.inc  = 1'b1;
      S_DONE:  cmd.emit = out_free;
      default: cmd = '0;
    endcase
  end

  // output word valid: set on load, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/kch_dp.sv
// Datapath: rolling k-mer, count table, count histogram, output register
module kch_dp import kch_pkg::*; #(
  parameter int MAX_K     = 8,
  parameter int COUNT_CAP = 1023
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  kch_cmd_t    cmd,
  output kch_sts_t    sts,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_symbol,
  input  logic [15:0] in_raw_key,
  input  logic [9:0]  in_count_index,
  output logic [15:0] out_kmer_code,
  output logic        out_was_counted,
  output logic [16:0] out_hist_entry,
  output logic [9:0]  out_largest_count,
  output logic        out_count_saturated
);

  localparam int KEY_W      = 2 * MAX_K;
  localparam int TBL_DEPTH  = 1 << KEY_W;
  localparam int CNT_W      = $clog2(COUNT_CAP + 1);
  localparam int HIST_DEPTH = COUNT_CAP + 1;
  localparam int HIST_W     = KEY_W + 1;
  localparam int K_W        = $clog2(MAX_K + 1);
  localparam int CLR_DEPTH  = (TBL_DEPTH > HIST_DEPTH) ? TBL_DEPTH : HIST_DEPTH;
  localparam int CLR_W      = $clog2(CLR_DEPTH);
  localparam logic [KEY_W-1:0] KEY_ONES = '1;

  logic [3:0]        k_len;
  logic [K_W-1:0]    k_eff;
  logic [KEY_W-1:0]  key_mask;
  logic [KEY_W-1:0]  rolling;
  logic [KEY_W-1:0]  rolling_shift;
  logic [K_W-1:0]    fill;
  logic [K_W-1:0]    fill_next;
  logic [KEY_W-1:0]  key_in;
  logic              count_in;

  logic [1:0]        op_q;
  logic [9:0]        idx_q;
  logic [KEY_W-1:0]  key_q;
  logic              counting_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  cnt_inc;
  logic              counted_q;
  logic              sat_q;
  logic [HIST_W-1:0] hist_res_q;
  logic [HIST_W-1:0] distinct;
  logic [CNT_W-1:0]  top;
  logic [HIST_W-1:0] all_kmers;
  logic [HIST_W-1:0] zero_avail;
  logic              will_count;

  logic [CLR_W-1:0]  clr_cnt;
  logic              clr_in_tbl;
  logic              clr_in_hist;

  logic              tbl_we;
  logic [KEY_W-1:0]  tbl_waddr;
  logic [CNT_W-1:0]  tbl_wdata;
  logic [CNT_W-1:0]  tbl_q;
  logic              hist_we;
  logic [CNT_W-1:0]  hist_waddr;
  logic [HIST_W-1:0] hist_wdata;
  logic [CNT_W-1:0]  hist_raddr;
  logic [HIST_W-1:0] hist_q;

  // effective k: zero acts as 1, values above MAX_K clamp
  always_comb begin
    priority if (k_len == 4'd0) begin
      k_eff = K_W'(1);
    end else if (k_len > 4'(MAX_K)) begin
      k_eff = K_W'(MAX_K);
    end else begin
      k_eff = K_W'(k_len);
    end
  end

  assign key_mask  = ~(KEY_ONES << {k_eff, 1'b0});
  assign all_kmers = HIST_W'(1) << {k_eff, 1'b0};
  assign zero_avail = (all_kmers > distinct) ? (all_kmers - distinct) : '0;

  // key of the incoming word
  assign rolling_shift = ((rolling << 2) | KEY_W'(in_symbol)) & key_mask;
  assign fill_next     = (fill < k_eff) ? (fill + K_W'(1)) : fill;
  assign key_in   = (in_op == OP_SHIFT) ? rolling_shift : (KEY_W'(in_raw_key) & key_mask);
  assign count_in = ((in_op == OP_SHIFT) && (fill_next >= k_eff)) || (in_op == OP_RAW);

  // config register and rolling window
  always_ff @(posedge clk) begin
    if (rst) begin
      k_len   <= KSIZE_RESET;
      rolling <= '0;
      fill    <= '0;
    end else if (cfg_we) begin
      k_len   <= cfg_wdata;
      rolling <= '0;
      fill    <= '0;
    end else if (cmd.accept && (in_op == OP_SHIFT)) begin
      rolling <= rolling_shift;
      fill    <= fill_next;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q       <= in_op;
      idx_q      <= in_count_index;
      key_q      <= key_in;
      counting_q <= count_in;
    end
  end

  // count lookup result
  assign will_count = counting_q && (tbl_q < CNT_W'(COUNT_CAP));
  assign cnt_inc    = cnt_q + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      cnt_q     <= tbl_q;
      counted_q <= will_count;
      sat_q     <= counting_q &&
                   ((tbl_q >= CNT_W'(COUNT_CAP)) || (tbl_q == CNT_W'(COUNT_CAP - 1)));
      priority if (op_q != OP_QUERY) begin
        hist_res_q <= '0;
      end else if (idx_q == 10'd0) begin
        hist_res_q <= zero_avail;
      end else if (17'(idx_q) <= 17'(COUNT_CAP)) begin
        hist_res_q <= hist_q;
      end else begin
        hist_res_q <= '0;
      end
    end
  end

  // distinct keys and largest count
  always_ff @(posedge clk) begin
    if (rst) begin
      distinct <= '0;
      top      <= '0;
    end else begin
      if (cmd.look && will_count && (tbl_q == '0)) begin
        distinct <= distinct + HIST_W'(1);
      end
      if (cmd.inc && (cnt_inc > top)) begin
        top <= cnt_inc;
      end
    end
  end

  // clearing sweep over both memories
  assign clr_in_tbl   = {1'b0, clr_cnt} < (CLR_W + 1)'(TBL_DEPTH);
  assign clr_in_hist  = {1'b0, clr_cnt} < (CLR_W + 1)'(HIST_DEPTH);
  assign sts.clr_last = (clr_cnt == CLR_W'(CLR_DEPTH - 1));
  assign sts.will_count = will_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + CLR_W'(1);
    end
  end

  // count table port control
  always_comb begin
    if (cmd.clear) begin
      tbl_we    = clr_in_tbl;
      tbl_waddr = KEY_W'(clr_cnt);
      tbl_wdata = '0;
    end else begin
      tbl_we    = cmd.look && will_count;
      tbl_waddr = key_q;
      tbl_wdata = tbl_q + CNT_W'(1);
    end
  end

  // histogram read: query index at accept, old count at lookup, new count at decrement
  always_comb begin
    priority if (cmd.look) begin
      hist_raddr = tbl_q;
    end else if (cmd.dec) begin
      hist_raddr = cnt_inc;
    end else begin
      hist_raddr = CNT_W'(in_count_index);
    end
  end

  // histogram write: clear, decrement old bin, increment new bin
  always_comb begin
    priority if (cmd.clear) begin
      hist_we    = clr_in_hist;
      hist_waddr = CNT_W'(clr_cnt);
      hist_wdata = '0;
    end else if (cmd.dec) begin
      hist_we    = (cnt_q != '0);
      hist_waddr = cnt_q;
      hist_wdata = hist_q - HIST_W'(1);
    end else if (cmd.inc) begin
      hist_we    = 1'b1;
      hist_waddr = cnt_inc;
      hist_wdata = hist_q + HIST_W'(1);
    end else begin
      hist_we    = 1'b0;
      hist_waddr = cnt_q;
      hist_wdata = hist_q;
    end
  end

  kch_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (key_in),
    .rdata (tbl_q)
  );

  kch_ram #(
    .WIDTH (HIST_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kmer_code       <= 16'(rolling);
      out_was_counted     <= counted_q;
      out_hist_entry      <= 17'(hist_res_q);
      out_largest_count   <= 10'(top);
      out_count_saturated <= sat_q;
    end
  end

endmodule

// File: hw/rtl/kmer_count_histogram.sv
// Top level of the k-mer counter with count histogram
//
//   channel  dir  word contents
//   items    in   op, symbol, raw_key, count_index
//   results  out  kmer_code, was_counted, hist_entry, largest_count, count_saturated
//   cfg      in   cfg_we / cfg_wdata: k-mer length, write only
//
// A counting word steps through accept, lookup, histogram decrement, histogram
// increment and load; a word that is not counted goes from lookup to load. The
// steps follow dependent read-modify-writes on the registered-read histogram RAM.
// After reset a clearing pass of max(4^MAX_K, COUNT_CAP+1) rows (65536 by default)
// zeroes both memories with items.ready low. A result waits in the output register;
// the next word is accepted meanwhile and stalls in its last step until it frees.
module kmer_count_histogram import kch_pkg::*; #(
  parameter int MAX_K     = 8,
  parameter int COUNT_CAP = 1023
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  kch_in_if.sink      items,
  kch_out_if.source   results
);

  kch_cmd_t cmd;
  kch_sts_t sts;

  kch_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kch_dp #(
    .MAX_K     (MAX_K),
    .COUNT_CAP (COUNT_CAP)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (items.op),
    .in_symbol           (items.symbol),
    .in_raw_key          (items.raw_key),
    .in_count_index      (items.count_index),
    .out_kmer_code       (results.kmer_code),
    .out_was_counted     (results.was_counted),
    .out_hist_entry      (results.hist_entry),
    .out_largest_count   (results.largest_count),
    .out_count_saturated (results.count_saturated)
  );

endmodule

// File: hw/rtl/kch_checker.sv
// Port-level checks of the k-mer counter, bound to the top level
`include "kmer_count_histogram_defines.svh"

module kch_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] kmer_code,
  input logic        was_counted,
  input logic [16:0] hist_entry
);

  // one word in work at a time
  `KCH_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready, "word accepted while busy")

  // only a query reports a histogram entry, and a query counts nothing
  `KCH_ASSERT_SAME(a_count_no_hist, out_valid && was_counted, hist_entry == 17'd0, "count with histogram entry")

  // stalled result word holds
  `KCH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kmer_code) && $stable(hist_entry), "stalled result changed")

endmodule

bind kmer_count_histogram kch_checker u_kch_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .kmer_code   (results.kmer_code),
  .was_counted (results.was_counted),
  .hist_entry  (results.hist_entry)
);
